FILE: rtl/atrlm_pkg.sv
// ----------------------------------------------------------------------------
// atrlm_pkg
// Shared types, codes and prefix tables for the AT response line matcher.
// ----------------------------------------------------------------------------
package atrlm_pkg;

   localparam int LINE_LIMIT_DEF  = 64;
   localparam int MATCH_CHARS_DEF = 8;

   localparam logic [7:0] CHAR_LF = 8'd10;
   localparam logic [7:0] CHAR_CR = 8'd13;

   localparam logic [7:0] STD_ERR_SHORT_LEN = 8'd5;
   localparam logic [7:0] STD_ERR_LONG_LEN  = 8'd11;

   localparam logic [63:0] EXPECTED_TEXT_RST = 64'd19279;
   localparam logic [3:0]  EXPECTED_LEN_RST  = 4'd2;

   typedef enum logic [2:0] {
      CODE_TEXT     = 3'd0,
      CODE_MATCH    = 3'd1,
      CODE_ERROR    = 3'd2,
      CODE_OTHER    = 3'd3,
      CODE_OVERFLOW = 3'd4,
      CODE_NODATA   = 3'd5
   } code_type;

   typedef enum logic [2:0] {
      REG_EXPECTED_TEXT = 3'd0,
      REG_EXPECTED_LEN  = 3'd1,
      REG_ERROR_MODE    = 3'd2,
      REG_ERROR_TEXT    = 3'd3,
      REG_ERROR_LEN     = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      ERRMODE_NONE     = 2'd0,
      ERRMODE_STANDARD = 2'd1,
      ERRMODE_CUSTOM   = 2'd2,
      ERRMODE_RSVD     = 2'd3
   } err_mode_type;

   typedef struct packed {
      logic [63:0] expected_text;
      logic [3:0]  expected_len;
      logic [1:0]  error_mode;
      logic [63:0] error_text;
      logic [3:0]  error_len;
   } cfg_type;

   typedef struct packed {
      logic [7:0] char_count;
      logic       prev_cr;
      logic       exp_match;
      logic       cus_match;
      logic [2:0] std_match;
   } line_state_type;

   typedef struct packed {
      logic [2:0] code;
      logic [7:0] out_byte;
      logic [7:0] line_length;
   } result_type;

   localparam line_state_type LINE_STATE_RST = '{
      char_count: 8'd0, prev_cr: 1'b0, exp_match: 1'b1,
      cus_match: 1'b1, std_match: 3'b111};

   // "ERROR"
   function automatic logic [7:0] std_err_short_char(input logic [2:0] pos);
      logic [7:0] ch;
      unique case (pos)
         3'd0:    ch = "E";
         3'd1:    ch = "R";
         3'd2:    ch = "R";
         3'd3:    ch = "O";
         3'd4:    ch = "R";
         default: ch = 8'd0;
      endcase
      return ch;
   endfunction

   // "+CME ERROR:" / "+CMS ERROR:", differing only at position 3
   function automatic logic [7:0] std_err_long_char(input logic [3:0] pos,
                                                    input logic       cms);
      logic [7:0] ch;
      unique case (pos)
         4'd0:    ch = "+";
         4'd1:    ch = "C";
         4'd2:    ch = "M";
         4'd3:    ch = cms ? "S" : "E";
         4'd4:    ch = " ";
         4'd5:    ch = "E";
         4'd6:    ch = "R";
         4'd7:    ch = "R";
         4'd8:    ch = "O";
         4'd9:    ch = "R";
         4'd10:   ch = ":";
         default: ch = 8'd0;
      endcase
      return ch;
   endfunction

endpackage

FILE: rtl/atrlm_if.sv
// ----------------------------------------------------------------------------
// atrlm channel interfaces
// Valid/ready channels for receive items, results and register writes.
// ----------------------------------------------------------------------------
interface atrlm_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] rx_byte;

   modport source (output valid, output kind, output rx_byte, input ready);
   modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface atrlm_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] code;
   logic [7:0] out_byte;
   logic [7:0] line_length;

   modport source (output valid, output code, output out_byte, output line_length,
                   input ready);
   modport sink   (input valid, input code, input out_byte, input line_length,
                   output ready);
endinterface

interface atrlm_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/atrlm_step.sv
// ----------------------------------------------------------------------------
// atrlm_step
// Per-byte line update: prefix tracking, line end classification, overflow and no-data items.
// ----------------------------------------------------------------------------
module atrlm_step
   import atrlm_pkg::*;
#(
   parameter int LINE_LIMIT  = LINE_LIMIT_DEF,
   parameter int MATCH_CHARS = MATCH_CHARS_DEF
) (
   input  cfg_type        cfg,
   input  line_state_type cur,
   input  logic           kind,
   input  logic [7:0]     rx_byte,
   output line_state_type nxt,
   output logic           res_valid,
   output result_type     res
);

   localparam logic [3:0] MATCH_MAX = 4'(MATCH_CHARS);
   localparam logic [7:0] LIMIT     = 8'(LINE_LIMIT);

   logic [3:0] elen;
   logic [3:0] glen;
   logic [7:0] count;
   logic       is_crlf;
   logic       line_end;
   logic       exp_hit;
   logic       std_hit;
   logic       cus_hit;
   logic       e_miss;
   logic       g_miss;
   logic       s0_miss;
   logic       s1_miss;
   logic       s2_miss;

   assign count = cur.char_count;
   assign elen  = (cfg.expected_len > MATCH_MAX) ? MATCH_MAX : cfg.expected_len;
   assign glen  = (cfg.error_len > MATCH_MAX) ? MATCH_MAX : cfg.error_len;

   assign is_crlf  = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);
   assign line_end = (rx_byte == CHAR_LF) && (count != 8'd0) && cur.prev_cr;

   // per-character mismatch against each prefix; positions past a prefix never miss
   assign e_miss  = (count < {4'd0, elen}) &&
                    (cfg.expected_text[{count[2:0], 3'b000} +: 8] != rx_byte);
   assign g_miss  = (count < {4'd0, glen}) &&
                    (cfg.error_text[{count[2:0], 3'b000} +: 8] != rx_byte);
   assign s0_miss = (count < STD_ERR_SHORT_LEN) &&
                    (std_err_short_char(count[2:0]) != rx_byte);
   assign s1_miss = (count < STD_ERR_LONG_LEN) &&
                    (std_err_long_char(count[3:0], 1'b0) != rx_byte);
   assign s2_miss = (count < STD_ERR_LONG_LEN) &&
                    (std_err_long_char(count[3:0], 1'b1) != rx_byte);

   assign exp_hit = cur.exp_match && (count >= {4'd0, elen});
   assign std_hit = (cur.std_match[0] && (count >= STD_ERR_SHORT_LEN)) ||
                    (cur.std_match[1] && (count >= STD_ERR_LONG_LEN)) ||
                    (cur.std_match[2] && (count >= STD_ERR_LONG_LEN));
   assign cus_hit = cur.cus_match && (count >= {4'd0, glen});

   always_comb begin
      nxt       = cur;
      res_valid = 1'b0;
      res.code        = CODE_OTHER;
      res.out_byte    = 8'd0;
      res.line_length = count;
      priority if (kind) begin
         res_valid = 1'b1;
         res.code  = CODE_NODATA;
         nxt       = LINE_STATE_RST;
      end else if (!is_crlf && (count >= LIMIT)) begin
         res_valid = 1'b1;
         res.code  = CODE_OVERFLOW;
         nxt       = LINE_STATE_RST;
      end else if (!is_crlf) begin
         res_valid       = 1'b1;
         res.code        = CODE_TEXT;
         res.out_byte    = rx_byte;
         res.line_length = count + 8'd1;
         nxt.char_count  = count + 8'd1;
         nxt.prev_cr     = 1'b0;
         nxt.exp_match   = cur.exp_match & ~e_miss;
         nxt.cus_match   = cur.cus_match & ~g_miss;
         nxt.std_match   = cur.std_match & ~{s2_miss, s1_miss, s0_miss};
      end else if (line_end) begin
         res_valid = 1'b1;
         nxt       = LINE_STATE_RST;
         if (exp_hit) begin
            res.code = CODE_MATCH;
         end else if ((cfg.error_mode == ERRMODE_STANDARD) && std_hit) begin
            res.code = CODE_ERROR;
         end else if ((cfg.error_mode == ERRMODE_CUSTOM) && cus_hit) begin
            res.code = CODE_ERROR;
         end
      end else begin
         nxt.prev_cr = (rx_byte == CHAR_CR);
      end
   end

endmodule

FILE: rtl/at_response_line_matcher.sv
// ----------------------------------------------------------------------------
// at_response_line_matcher
// Assembles modem response lines byte by byte and classifies them by prefix.
// ----------------------------------------------------------------------------
// Takes one receive item per clock cycle with no bubbles while the result
// register is not stalled: an item is held in the input register, is
// processed by a single pass of compare logic against the line state, and
// its result (if any) is then written into the result register once it is
// free. A stalled result register holds the input register; an empty input
// register still takes a new item while a finished result waits. Register
// writes are taken every cycle and must only happen while the block is idle.
module at_response_line_matcher
   import atrlm_pkg::*;
#(
   parameter int LINE_LIMIT  = LINE_LIMIT_DEF,
   parameter int MATCH_CHARS = MATCH_CHARS_DEF
) (
   input logic          clock,
   input logic          reset,
   atrlm_req_if.sink    req_if,
   atrlm_rsp_if.source  rsp_if,
   atrlm_csr_if.sink    csr_if
);

   cfg_type        cfg_ff, cfg_in;
   line_state_type state_ff, state_nxt;
   logic           in_valid_ff, in_valid_in;
   logic           in_kind_ff;
   logic [7:0]     in_byte_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   result_type     rsp_ff;
   result_type     step_res;
   logic           step_valid;
   logic           proc_go;
   logic           req_beat;

   assign proc_go       = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || proc_go;
   assign req_beat      = req_if.valid && req_if.ready;
   assign csr_if.ready  = 1'b1;

   atrlm_step #(
      .LINE_LIMIT  (LINE_LIMIT),
      .MATCH_CHARS (MATCH_CHARS)
   ) u_step (
      .cfg       (cfg_ff),
      .cur       (state_ff),
      .kind      (in_kind_ff),
      .rx_byte   (in_byte_ff),
      .nxt       (state_nxt),
      .res_valid (step_valid),
      .res       (step_res)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            REG_EXPECTED_TEXT: cfg_in.expected_text = csr_if.data;
            REG_EXPECTED_LEN:  cfg_in.expected_len  = csr_if.data[3:0];
            REG_ERROR_MODE:    cfg_in.error_mode    = csr_if.data[1:0];
            REG_ERROR_TEXT:    cfg_in.error_text    = csr_if.data;
            REG_ERROR_LEN:     cfg_in.error_len     = csr_if.data[3:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_beat) begin
         in_valid_in = 1'b1;
      end else if (proc_go) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (proc_go) begin
         rsp_valid_in = step_valid;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{expected_text: EXPECTED_TEXT_RST, expected_len: EXPECTED_LEN_RST,
                     error_mode: ERRMODE_NONE, error_text: 64'd0, error_len: 4'd0};
         state_ff     <= LINE_STATE_RST;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (proc_go) begin
            state_ff <= state_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_kind_ff <= req_if.kind;
         in_byte_ff <= req_if.rx_byte;
      end
      if (proc_go && step_valid) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.code        = rsp_ff.code;
   assign rsp_if.out_byte    = rsp_ff.out_byte;
   assign rsp_if.line_length = rsp_ff.line_length;

endmodule

FILE: rtl/atrlm_checker.sv
// ----------------------------------------------------------------------------
// atrlm_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module atrlm_checker
   import atrlm_pkg::*;
#(
   parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_code,
   input logic [7:0] rsp_out_byte,
   input logic [7:0] rsp_line_length
);

   localparam logic [7:0] LIMIT = 8'(LINE_LIMIT);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code)
         && $stable(rsp_line_length))
      else $error("stalled result changed");

   a_byte_only_text: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_code != CODE_TEXT) |-> (rsp_out_byte == 8'd0))
      else $error("nonzero byte on a non-text result");

   a_text_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_code == CODE_TEXT) |->
         (rsp_line_length != 8'd0) && (rsp_line_length <= LIMIT))
      else $error("text result length out of range");

   a_line_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_code == CODE_MATCH) || (rsp_code == CODE_ERROR) ||
                    (rsp_code == CODE_OTHER)) |-> (rsp_line_length != 8'd0))
      else $error("line result with empty line");

endmodule

bind at_response_line_matcher atrlm_checker #(
   .LINE_LIMIT (LINE_LIMIT)
) u_atrlm_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_code        (rsp_if.code),
   .rsp_out_byte    (rsp_if.out_byte),
   .rsp_line_length (rsp_if.line_length)
);

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb: AT response line matcher testbench
// Drives receive beats and register writes into the matcher. A line-state
// predictor in the bench computes the expected results, and each result beat
// is checked against the oldest one. A short directed pass is followed by
// random response lines, some well formed and some broken, under several
// prefix settings. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import atrlm_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 8;
   localparam int LINE_LIMIT    = LINE_LIMIT_DEF;
   localparam int MATCH_CHARS   = MATCH_CHARS_DEF;
   localparam int ERR_SHORT     = STD_ERR_SHORT_LEN;
   localparam int ERR_LONG      = STD_ERR_LONG_LEN;

   // first character in the top byte
   localparam logic [39:0] ERR_PLAIN_TEXT = "ERROR";
   localparam logic [87:0] ERR_CME_TEXT   = "+CME ERROR:";
   localparam logic [87:0] ERR_CMS_TEXT   = "+CMS ERROR:";

   logic clock = 1'b0;
   logic reset = 1'b1;

   atrlm_req_if req_ch ();
   atrlm_rsp_if rsp_ch ();
   atrlm_csr_if csr_ch ();

   at_response_line_matcher u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always #1 clock = ~clock;

   // register copy
   logic [63:0]  cfg_exp_text = EXPECTED_TEXT_RST;
   logic [3:0]   cfg_exp_len  = EXPECTED_LEN_RST;
   err_mode_type cfg_err_mode = ERRMODE_NONE;
   logic [63:0]  cfg_err_text = '0;
   logic [3:0]   cfg_err_len  = '0;

   // line state copy
   int       line_count  = 0;
   bit       line_prev_cr = 1'b0;
   bit       line_exp_ok = 1'b1;
   bit       line_cus_ok = 1'b1;
   bit [2:0] line_std_ok = 3'b111;

   result_type pending_results [$];
   result_type rsp_seen;
   result_type rsp_want;

   int  mismatch_count = 0;
   int  beats_sent     = 0;
   int  cycle_count    = 0;
   int  rsp_hold       = 0;
   bit  no_idle        = 1'b0;

   function automatic int clamp_len(input logic [3:0] len);
      return (len > MATCH_CHARS) ? MATCH_CHARS : int'(len);
   endfunction

   function automatic int std_err_len(input int k);
      return (k == 0) ? ERR_SHORT : ERR_LONG;
   endfunction

   function automatic logic [7:0] std_err_char(input int k, input int pos);
      if (k == 0)
         return ERR_PLAIN_TEXT[8*(ERR_SHORT-1-pos) +: 8];
      else if (k == 1)
         return ERR_CME_TEXT[8*(ERR_LONG-1-pos) +: 8];
      return ERR_CMS_TEXT[8*(ERR_LONG-1-pos) +: 8];
   endfunction

   function automatic void clear_line();
      line_count   = 0;
      line_prev_cr = 1'b0;
      line_exp_ok  = 1'b1;
      line_cus_ok  = 1'b1;
      line_std_ok  = 3'b111;
   endfunction

   // Advances the line state by one beat; returns 1 when a result is due.
   function automatic bit classify_beat(input logic kind, input logic [7:0] ch,
                                        output result_type res);
      bit is_err;
      res = '0;
      res.line_length = 8'(line_count);
      if (kind) begin
         res.code = CODE_NODATA;
         clear_line();
         return 1'b1;
      end
      if (ch != CHAR_LF && ch != CHAR_CR) begin
         if (line_count >= LINE_LIMIT) begin
            res.code = CODE_OVERFLOW;
            clear_line();
            return 1'b1;
         end
         if (line_count < clamp_len(cfg_exp_len) && cfg_exp_text[8*line_count +: 8] != ch)
            line_exp_ok = 1'b0;
         if (line_count < clamp_len(cfg_err_len) && cfg_err_text[8*line_count +: 8] != ch)
            line_cus_ok = 1'b0;
         for (int k = 0; k < 3; k++) begin
            if (line_count < std_err_len(k) && std_err_char(k, line_count) != ch)
               line_std_ok[k] = 1'b0;
         end
         line_count++;
         line_prev_cr    = 1'b0;
         res.code        = CODE_TEXT;
         res.out_byte    = ch;
         res.line_length = 8'(line_count);
         return 1'b1;
      end
      if (ch == CHAR_LF && line_count > 0 && line_prev_cr) begin
         is_err = 1'b0;
         if (cfg_err_mode == ERRMODE_STANDARD) begin
            for (int k = 0; k < 3; k++) begin
               if (line_std_ok[k] && line_count >= std_err_len(k))
                  is_err = 1'b1;
            end
         end else if (cfg_err_mode == ERRMODE_CUSTOM) begin
            is_err = line_cus_ok && line_count >= clamp_len(cfg_err_len);
         end
         if (line_exp_ok && line_count >= clamp_len(cfg_exp_len))
            res.code = CODE_MATCH;
         else if (is_err)
            res.code = CODE_ERROR;
         else
            res.code = CODE_OTHER;
         clear_line();
         return 1'b1;
      end
      line_prev_cr = (ch == CHAR_CR);
      return 1'b0;
   endfunction

   function automatic int gap_cycles();
      int r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] line_char();
      logic [7:0] c;
      case ($urandom_range(0, 15))
         0: c = 8'h00;
         1: c = 8'hFF;
         2: begin
            c = 8'($urandom);
            if (c == CHAR_CR || c == CHAR_LF)
               c = c ^ 8'h80;
         end
         default: c = 8'($urandom_range(32, 126));
      endcase
      return c;
   endfunction

   function automatic logic [63:0] prefix_text();
      logic [63:0] t;
      for (int i = 0; i < 8; i++)
         t[8*i +: 8] = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(33, 126));
      return t;
   endfunction

   // result side: random stalls
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(0, 4) == 0)
            rsp_hold = gap_cycles();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         rsp_seen = '{code: rsp_ch.code, out_byte: rsp_ch.out_byte,
                      line_length: rsp_ch.line_length};
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat: code %0d byte %02h length %0d",
                     $time, rsp_seen.code, rsp_seen.out_byte, rsp_seen.line_length);
            mismatch_count++;
         end else begin
            rsp_want = pending_results.pop_front();
            if (rsp_seen !== rsp_want) begin
               $display("%0t: mismatch: expected code %0d byte %02h length %0d, got code %0d byte %02h length %0d",
                        $time, rsp_want.code, rsp_want.out_byte, rsp_want.line_length,
                        rsp_seen.code, rsp_seen.out_byte, rsp_seen.line_length);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("[at_response_line_matcher] ERROR");
         $finish;
      end
   end

   // Called and returns at a falling edge.
   task automatic send_beat(input logic kind, input logic [7:0] data);
      result_type res;
      int gap;
      gap = gap_cycles();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.kind    <= kind;
      req_ch.rx_byte <= data;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      if (classify_beat(kind, data, res))
         pending_results.push_back(res);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      // a beat with no result may still sit in the pipe
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Leaves valid high; the caller lowers it after the last write.
   task automatic write_reg(input reg_index_type idx, input logic [63:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (csr_ch.ready !== 1'b1) @(posedge clock);
      case (idx)
         REG_EXPECTED_TEXT: cfg_exp_text = value;
         REG_EXPECTED_LEN:  cfg_exp_len  = value[3:0];
         REG_ERROR_MODE:    cfg_err_mode = err_mode_type'(value[1:0]);
         REG_ERROR_TEXT:    cfg_err_text = value;
         REG_ERROR_LEN:     cfg_err_len  = value[3:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic load_config(input logic [63:0] exp_text, input logic [3:0] exp_len,
                              input err_mode_type mode, input logic [63:0] err_text,
                              input logic [3:0] err_len);
      drain();
      write_reg(REG_EXPECTED_TEXT, exp_text);
      write_reg(REG_EXPECTED_LEN, 64'(exp_len));
      write_reg(REG_ERROR_MODE, 64'(mode));
      write_reg(REG_ERROR_TEXT, err_text);
      write_reg(REG_ERROR_LEN, 64'(err_len));
      csr_ch.valid <= 1'b0;
   endtask

   task automatic send_random_line();
      logic [7:0] text [$];
      int pick;
      int k;
      int ends;
      pick = $urandom_range(0, 19);
      if (pick < 5) begin
         for (int i = 0; i < clamp_len(cfg_exp_len); i++)
            text.push_back(cfg_exp_text[8*i +: 8]);
      end else if (pick < 8) begin
         for (int i = 0; i < clamp_len(cfg_err_len); i++)
            text.push_back(cfg_err_text[8*i +: 8]);
      end else if (pick < 14) begin
         k = $urandom_range(0, 2);
         for (int i = 0; i < std_err_len(k); i++)
            text.push_back(std_err_char(k, i));
      end else if (pick < 19) begin
         repeat ($urandom_range(0, 8)) text.push_back(line_char());
      end else begin
         // runs up to and past the line limit
         repeat ($urandom_range(LINE_LIMIT - 4, LINE_LIMIT + 6)) text.push_back(line_char());
      end
      if (text.size() > 0 && $urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, text.size())) void'(text.pop_back());
      if (text.size() > 0 && $urandom_range(0, 5) == 0)
         text[$urandom_range(0, text.size() - 1)] = line_char();
      repeat ($urandom_range(0, 4)) text.push_back(line_char());
      foreach (text[i])
         send_beat(1'b0, text[i]);

      ends = $urandom_range(0, 19);
      if (ends < 14) begin
         send_beat(1'b0, CHAR_CR);
         send_beat(1'b0, CHAR_LF);
      end else if (ends == 14) begin
         send_beat(1'b1, 8'($urandom));
      end else if (ends == 15) begin
         send_beat(1'b0, CHAR_LF);
         send_beat(1'b0, CHAR_CR);
         send_beat(1'b0, CHAR_LF);
      end else if (ends == 16) begin
         send_beat(1'b0, CHAR_CR);
         send_beat(1'b0, CHAR_CR);
         send_beat(1'b0, CHAR_LF);
      end else if (ends == 17) begin
         send_beat(1'b0, CHAR_CR);
         send_beat(1'b0, line_char());
         send_beat(1'b0, CHAR_CR);
         send_beat(1'b0, CHAR_LF);
      end else if (ends == 18) begin
         send_beat(1'b0, CHAR_LF);
      end
      // otherwise the line runs on into the next one
   endtask

   task automatic run_traffic(input int beats);
      int stop_at;
      stop_at = beats_sent + beats;
      while (beats_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0)
            no_idle = ~no_idle;
         if ($urandom_range(0, 59) == 0)
            drain();
         if ($urandom_range(0, 7) == 0)
            send_beat($urandom_range(0, 3) == 0,
                      $urandom_range(0, 1) ? 8'($urandom) :
                      ($urandom_range(0, 1) ? CHAR_CR : CHAR_LF));
         else
            send_random_line();
      end
   endtask

   task automatic test_directed_basics();
      // settings out of reset expect "OK"
      send_beat(1'b0, "O");
      send_beat(1'b0, "K");
      send_beat(1'b0, CHAR_CR);
      send_beat(1'b0, CHAR_LF);
      send_beat(1'b0, CHAR_LF);    // LF with nothing stored
      send_beat(1'b0, CHAR_CR);
      send_beat(1'b0, CHAR_LF);    // CR LF, still empty
      send_beat(1'b0, 8'h00);
      send_beat(1'b0, 8'hFF);
      send_beat(1'b0, CHAR_LF);    // LF not after CR
      send_beat(1'b1, 8'hA5);      // silence drops the line
      send_beat(1'b0, "X");
      send_beat(1'b0, CHAR_CR);    // CR mid-line is not stored
      send_beat(1'b0, "O");
      send_beat(1'b0, "K");
      send_beat(1'b0, CHAR_CR);
      send_beat(1'b0, CHAR_LF);
      send_beat(1'b0, "O");
      send_beat(1'b0, "K");
      send_beat(1'b0, "!");
      send_beat(1'b0, CHAR_CR);
      send_beat(1'b0, CHAR_LF);
      run_traffic(100);
   endtask

   task automatic test_standard_errors();
      // expected text overlaps "+CME ERROR:" so the match wins there
      load_config(64'({"E", "M", "C", "+"}), 4'd4, ERRMODE_STANDARD, '0, 4'd0);
      run_traffic(250);
   endtask

   task automatic test_custom_full_width();
      load_config(prefix_text(), 4'd8, ERRMODE_CUSTOM, prefix_text(), 4'd8);
      run_traffic(250);
   endtask

   task automatic test_oversized_lengths();
      load_config(prefix_text(), 4'd15, ERRMODE_RSVD, prefix_text(), 4'd15);
      run_traffic(200);
   endtask

   task automatic test_match_every_line();
      load_config('0, 4'd0, ERRMODE_STANDARD, prefix_text(), 4'd3);
      run_traffic(150);
   endtask

   task automatic test_zero_custom_length();
      load_config('0, 4'd3, ERRMODE_CUSTOM, '1, 4'd0);
      run_traffic(200);
   endtask

   task automatic test_all_ones_text();
      load_config('1, 4'd8, ERRMODE_CUSTOM, '1, 4'd5);
      run_traffic(150);
   endtask

   task automatic test_random_settings();
      repeat (2) begin
         load_config({$urandom, $urandom}, 4'($urandom_range(0, 15)),
                     err_mode_type'($urandom_range(0, 3)), {$urandom, $urandom},
                     4'($urandom_range(0, 15)));
         run_traffic(100);
         load_config(prefix_text(), 4'($urandom_range(0, 15)),
                     err_mode_type'($urandom_range(0, 3)), prefix_text(),
                     4'($urandom_range(0, 15)));
         run_traffic(100);
      end
   endtask

   initial begin
      int guard;
      req_ch.valid   = 1'b0;
      req_ch.kind    = 1'b0;
      req_ch.rx_byte = 8'h00;
      rsp_ch.ready   = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = REG_EXPECTED_TEXT;
      csr_ch.data    = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_basics();
      test_standard_errors();
      test_custom_full_width();
      test_oversized_lengths();
      test_match_every_line();
      test_zero_custom_length();
      test_all_ones_text();
      test_random_settings();

      req_ch.valid <= 1'b0;
      guard = 0;
      while (pending_results.size() != 0 && guard < 5000) begin
         @(negedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, pending_results.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("[at_response_line_matcher] OK");
      else
         $display("[at_response_line_matcher] ERROR");
      $finish;
   end

endmodule
